[rtl/core/srti_pkg.sv]
// package: shared constants and types for the stage rate time interpolator
package srti_pkg;

    localparam int MAX_STAGES_DEF      = 16;
    localparam int MAX_BREAKPOINTS_DEF = 16;

    localparam logic [1:0] FUNC_WR_BP   = 2'd0;
    localparam logic [1:0] FUNC_WR_RATE = 2'd1;
    localparam logic [1:0] FUNC_QUERY   = 2'd2;

    localparam logic [2:0] CFG_STAGE_COUNT  = 3'd0;
    localparam logic [2:0] CFG_TOTAL_COUNT  = 3'd1;
    localparam logic [2:0] CFG_BP_COUNT     = 3'd2;
    localparam logic [2:0] CFG_FINAL_RATE   = 3'd3;
    localparam logic [2:0] CFG_PENULT_BONUS = 3'd4;

    localparam int CFG_DATA_W = 32;

    // divider request and response
    typedef struct packed {
        logic        start;
        logic [63:0] numer;
        logic [31:0] denom;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

    // saturating 32-bit add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

[rtl/core/srti_div.sv]
// module: restoring divider, one quotient bit per cycle
module srti_div
    import srti_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [31:0] r_numer;
    logic [32:0] r_rem;
    logic [31:0] r_denom;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] w_trial;
    logic [32:0] w_shift;

    // shift in next numerator bit and try subtracting
    assign w_shift = {r_rem[31:0], r_numer[31]};
    assign w_trial = {1'b0, w_shift} - {2'b0, r_denom};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, quotient collects in the numerator register
    // upper numerator half is below the divisor, so it seeds the remainder
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_numer <= i_req.numer[31:0];
            r_denom <= i_req.denom;
            r_rem   <= {1'b0, i_req.numer[63:32]};
        end else if (r_busy) begin
            if (!w_trial[33]) begin
                r_rem   <= w_trial[32:0];
                r_numer <= {r_numer[30:0], 1'b1};
            end else begin
                r_rem   <= w_shift;
                r_numer <= {r_numer[30:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_numer;

endmodule

[rtl/core/stage_rate_time_interpolator.sv]
// top level: tables, query sequencer and result register
// Usage:
// Input channel (i_valid/o_stall) carries func, indices and data. func 0
// writes a breakpoint (low 16 bits), func 1 writes a rate entry, func 2
// queries a Q16.16 time; func 3 and out-of-range writes are dropped.
// Each load passes through ST_LOAD. A query emits total_stage_count result
// items on the output channel (o_valid/i_stall), stage 0 upward, last set
// on the final one. Breakpoint search scans one breakpoint per cycle; then
// each non-final stage takes one rate-memory read per interval up to the
// current one, plus a bit-serial division when a breakpoint above the time
// was found; the final stage takes its entry as is, and each result item
// one handshake. The single divider and the single rate-memory read port
// serialize this work; one item is worked on at a time.
// Reset clears control state and configuration registers to their defaults;
// tables are undefined until written. When the receiver stalls, the held
// result stays on the outputs and the sequencer waits.
module stage_rate_time_interpolator
    import srti_pkg::*;
#(
    parameter int MAX_STAGES      = MAX_STAGES_DEF,
    parameter int MAX_BREAKPOINTS = MAX_BREAKPOINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_func,
    input  logic [3:0]            i_row_index,
    input  logic [3:0]            i_column_index,
    input  logic [31:0]           i_data_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [3:0]            o_stage_index,
    output logic [31:0]           o_stage_rate,
    output logic                  o_last,
    output logic                  o_rate_mismatch,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SW = $clog2(MAX_STAGES);
    localparam int BW = $clog2(MAX_BREAKPOINTS);
    localparam int CW = $clog2(MAX_STAGES + 1);
    localparam int KW = $clog2(MAX_BREAKPOINTS + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SEARCH = 4'd1;
    localparam logic [3:0] ST_BOUNDS = 4'd2;
    localparam logic [3:0] ST_STAGE  = 4'd3;
    localparam logic [3:0] ST_ACC    = 4'd4;
    localparam logic [3:0] ST_CUR    = 4'd5;
    localparam logic [3:0] ST_DIV    = 4'd6;
    localparam logic [3:0] ST_FINAL  = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;
    localparam logic [3:0] ST_LOAD   = 4'd9;
    localparam logic [3:0] ST_RDWAIT = 4'd10;

    // configuration registers
    logic [4:0]  r_stage_count, r_total_count, r_bp_count;
    logic [31:0] r_final_rate, r_bonus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_count <= 5'd5;
            r_total_count <= 5'd5;
            r_bp_count    <= 5'd16;
            r_final_rate  <= '0;
            r_bonus       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STAGE_COUNT:  r_stage_count <= i_cfg_data[4:0];
                CFG_TOTAL_COUNT:  r_total_count <= i_cfg_data[4:0];
                CFG_BP_COUNT:     r_bp_count    <= i_cfg_data[4:0];
                CFG_FINAL_RATE:   r_final_rate  <= i_cfg_data;
                CFG_PENULT_BONUS: r_bonus       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective counts, clamped
    logic [CW-1:0] w_ns, w_nt;
    logic [KW-1:0] w_nb;
    always_comb begin
        if (r_stage_count < 5'd2) w_ns = CW'(2);
        else if (32'(r_stage_count) > MAX_STAGES) w_ns = CW'(MAX_STAGES);
        else w_ns = CW'(r_stage_count);
        if (r_bp_count < 5'd2) w_nb = KW'(2);
        else if (32'(r_bp_count) > MAX_BREAKPOINTS) w_nb = KW'(MAX_BREAKPOINTS);
        else w_nb = KW'(r_bp_count);
        if (32'(r_total_count) < 32'(w_ns)) w_nt = w_ns;
        else if (32'(r_total_count) > MAX_STAGES) w_nt = CW'(MAX_STAGES);
        else w_nt = CW'(r_total_count);
    end

    // memories
    logic [15:0] r_bp_mem [MAX_BREAKPOINTS];
    logic [31:0] r_rate_mem [MAX_STAGES*MAX_BREAKPOINTS];
    logic [15:0] r_bp_rd;
    logic [31:0] r_rate_rd;

    // control and item registers
    logic [3:0]    r_state;
    logic [31:0]   r_data;
    logic [KW-1:0] r_k;
    logic [BW-1:0] r_cur;
    logic          r_found;
    logic [15:0]   r_lo;
    logic [CW-1:0] r_s;
    logic [KW-1:0] r_j;
    logic [31:0]   r_acc;
    logic [31:0]   r_res [MAX_STAGES];
    logic          r_mismatch;
    logic          r_valid;
    logic [3:0]    r_pend;
    t_div_req      w_req;
    t_div_rsp      w_rsp;
    logic [BW-1:0] w_bp_addr;
    logic [SW+BW-1:0] w_rate_addr;
    logic          w_bp_re, w_rate_re;

    srti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_stall = (r_state != ST_IDLE);
    wire w_in_acc = i_valid && !o_stall;
    wire w_out_acc = r_valid && !i_stall;
    wire w_emit = (r_state == ST_EMIT) && (!r_valid || w_out_acc);

    // memory read and write ports
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_func == FUNC_WR_BP && 32'(i_row_index) < MAX_BREAKPOINTS)
            r_bp_mem[BW'(i_row_index)] <= i_data_value[15:0];
        if (w_in_acc && i_func == FUNC_WR_RATE && 32'(i_row_index) < MAX_STAGES
                && 32'(i_column_index) < MAX_BREAKPOINTS)
            r_rate_mem[{SW'(i_row_index), BW'(i_column_index)}] <= i_data_value;
        if (w_bp_re) r_bp_rd <= r_bp_mem[w_bp_addr];
        if (w_rate_re) r_rate_rd <= r_rate_mem[w_rate_addr];
    end

    // read address selection
    always_comb begin
        w_bp_re     = 1'b0;
        w_bp_addr   = BW'(r_k);
        w_rate_re   = 1'b0;
        w_rate_addr = {SW'(r_s), BW'(r_j)};
        unique case (r_state)
            ST_IDLE:   begin w_bp_re = 1'b1; w_bp_addr = '0; end
            ST_SEARCH: begin w_bp_re = 1'b1; w_bp_addr = BW'(r_k + KW'(1)); end
            ST_BOUNDS: begin w_bp_re = 1'b1; w_bp_addr = r_cur - BW'(1); end
            ST_STAGE:  begin w_rate_re = 1'b1; w_rate_addr = {SW'(r_s), BW'(r_j)}; end
            ST_ACC:    begin w_rate_re = 1'b1; w_rate_addr = {SW'(r_s), BW'(r_j + KW'(1))}; end
            default: ;
        endcase
    end

    // sequencer
    logic [31:0] r_hi32;
    logic [63:0] w_prod;
    logic [31:0] r_r;
    logic        r_divgo;
    assign w_prod = 64'(r_r) * 64'(r_data - {r_lo, 16'd0});

    logic [63:0] r_numer;
    logic [31:0] r_denom;
    always_comb begin
        w_req.start = r_divgo;
        w_req.numer = r_numer;
        w_req.denom = r_denom;
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_emit) begin
            r_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_divgo <= 1'b0;
        end else begin
            r_divgo <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (w_in_acc) begin
                    r_data <= i_data_value;
                    r_k <= '0; r_found <= 1'b0; r_mismatch <= 1'b0;
                    r_state <= (i_func == FUNC_QUERY) ? ST_SEARCH : ST_LOAD;
                end
                ST_LOAD: r_state <= ST_IDLE;
                // scan breakpoints; r_bp_rd holds entry r_k
                ST_SEARCH: begin
                    if ({r_bp_rd, 16'd0} > r_data) begin
                        r_found <= 1'b1; r_cur <= BW'(r_k); r_hi32 <= {r_bp_rd, 16'd0};
                        r_state <= ST_RDWAIT;
                    end else if (r_k + KW'(1) == w_nb) begin
                        r_cur <= BW'(r_k); r_hi32 <= {r_bp_rd, 16'd0};
                        r_state <= ST_RDWAIT;
                    end else r_k <= r_k + KW'(1);
                end
                ST_RDWAIT: begin
                    for (int i = 0; i < MAX_STAGES; i++) r_res[i] <= '0;
                    r_s <= '0;
                    r_state <= (r_cur == '0) ? ST_EMIT : ST_BOUNDS;
                end
                ST_BOUNDS: begin
                    r_j <= '0; r_acc <= '0;
                    r_state <= ST_CUR;
                end
                ST_CUR: begin
                    r_lo <= r_bp_rd;
                    r_j <= '0; r_acc <= '0;
                    r_state <= ST_STAGE;
                end
                // accumulate earlier intervals, then the current one
                ST_STAGE: r_state <= ST_ACC;
                ST_ACC: begin
                    if (r_j + KW'(1) < KW'(r_cur)) begin
                        r_acc <= sat_add(r_acc, r_rate_rd);
                        r_j <= r_j + KW'(1);
                    end else begin
                        r_r <= r_rate_rd;
                        r_state <= ST_DIV;
                        r_pend <= 4'd0;
                    end
                end
                // final stage takes its current-interval entry as is
                ST_DIV: begin
                    if (r_s + CW'(1) == w_ns) begin
                        r_res[SW'(r_s)] <= r_r;
                        r_mismatch <= (r_r != r_final_rate);
                        r_res[SW'(r_s - CW'(1))] <= sat_add(r_res[SW'(r_s - CW'(1))], r_bonus);
                        r_s <= '0;
                        r_state <= ST_EMIT;
                    end else if (!r_found) begin
                        r_res[SW'(r_s)] <= sat_add(r_acc, r_r);
                        r_state <= ST_FINAL;
                    end else if (r_pend == 4'd0) begin
                        r_numer <= w_prod;
                        r_denom <= r_hi32 - {r_lo, 16'd0};
                        r_divgo <= 1'b1;
                        r_pend <= 4'd1;
                    end else if (w_rsp.done) begin
                        r_res[SW'(r_s)] <= sat_add(r_acc, w_rsp.quot);
                        r_state <= ST_FINAL;
                    end
                end
                ST_FINAL: begin
                    r_s <= r_s + CW'(1);
                    r_j <= '0; r_acc <= '0;
                    r_state <= ST_STAGE;
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        o_stage_index <= 4'(r_s);
                        o_stage_rate <= r_res[SW'(r_s)];
                        o_last <= (r_s + CW'(1) == w_nt);
                        o_rate_mismatch <= r_mismatch;
                        if (r_s + CW'(1) == w_nt) r_state <= ST_IDLE;
                        else r_s <= r_s + CW'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;

endmodule

[rtl/core/srti_checker.sv]
// checker: port-level assertions for the interpolator
module srti_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [3:0]  o_stage_index,
    input logic [31:0] o_stage_rate,
    input logic        o_last
);

    // held result does not change while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_stage_index)
            && $stable(o_stage_rate) && $stable(o_last))
        else $error("result changed under stall");

    // no result item right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // handshake outputs are always known
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_valid, o_stall}))
        else $error("handshake output unknown");

    // a non-last item is followed by the next stage index
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last ##1 o_valid
            |-> o_stage_index == $past(o_stage_index) + 4'd1)
        else $error("stage order broken");

endmodule

bind stage_rate_time_interpolator srti_checker u_srti_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_stage_index (o_stage_index),
    .o_stage_rate  (o_stage_rate),
    .o_last        (o_last)
);

[dv/tb.sv]
// testbench for the stage rate time interpolator: table loads, queries and result checks
module tb;
    import srti_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1300;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] data;
    } t_item;

    typedef struct packed {
        logic [3:0]  stage;
        logic [31:0] rate;
        logic        last;
        logic        mismatch;
    } t_stage_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_func = '0;
    logic [3:0]  i_row_index = '0;
    logic [3:0]  i_column_index = '0;
    logic [31:0] i_data_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [3:0]  o_stage_index;
    logic [31:0] o_stage_rate;
    logic        o_last;
    logic        o_rate_mismatch;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    stage_rate_time_interpolator uut (.*);

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_item         pending_items[$];
    t_stage_result rate_expect_q[$];
    t_item         cur_item;

    // predictor state: tables and registers as the block should hold them
    logic [15:0] bp_shadow[16];
    logic [31:0] rate_shadow[16][16];
    logic [4:0]  stage_count_r = 5'd5;
    logic [4:0]  total_count_r = 5'd5;
    logic [4:0]  bp_count_r = 5'd16;
    logic [31:0] final_rate_r = '0;
    logic [31:0] bonus_r = '0;

    // stimulus-side copy of the breakpoints, for picking query times
    logic [15:0] bp_plan[16];

    int idle_pct = 0;
    int stall_pct = 0;
    logic hold_go = 1'b0;
    int hold_cnt = 0;
    int errors = 0;
    int n_queries = 0;
    int n_loads = 0;
    int n_results = 0;
    int quiet_cycles = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // apply one accepted item to the predictor
    task automatic predict_stage_rates(input t_item it);
        logic [31:0] rates[16];
        int ns, nt, nb, cur, s, j, k;
        bit found;
        bit mism;
        logic [63:0] lo, hi, dt, prod;
        logic [31:0] acc, r;
        t_stage_result res;
        found = 0;
        mism = 0;
        cur = 0;
        if (it.func == FUNC_WR_BP) begin
            bp_shadow[it.row] = it.data[15:0];
            n_loads++;
        end else if (it.func == FUNC_WR_RATE) begin
            rate_shadow[it.row][it.col] = it.data;
            n_loads++;
        end else if (it.func == FUNC_QUERY) begin
            n_queries++;
            ns = stage_count_r < 2 ? 2 : (stage_count_r > 16 ? 16 : stage_count_r);
            nt = total_count_r < ns ? ns : (total_count_r > 16 ? 16 : total_count_r);
            nb = bp_count_r < 2 ? 2 : (bp_count_r > 16 ? 16 : bp_count_r);
            for (k = 0; k < 16; k++) rates[k] = '0;
            // first breakpoint strictly above the time
            for (k = 0; k < nb && !found; k++) begin
                if ({16'h0, bp_shadow[k], 16'h0} > {32'h0, it.data}) begin
                    cur = k;
                    found = 1;
                end
            end
            if (!found) cur = nb - 1;
            if (cur >= 1) begin
                lo = {32'h0, bp_shadow[cur-1], 16'h0};
                hi = {32'h0, bp_shadow[cur], 16'h0};
                for (s = 0; s + 1 < ns; s++) begin
                    acc = '0;
                    r = rate_shadow[s][cur-1];
                    for (j = 0; j + 1 < cur; j++) acc = add_sat(acc, rate_shadow[s][j]);
                    if (found) begin
                        dt = {32'h0, it.data} - lo;
                        prod = {32'h0, r} * dt;
                        acc = add_sat(acc, 32'(prod / (hi - lo)));
                    end else begin
                        acc = add_sat(acc, r);
                    end
                    rates[s] = acc;
                end
                rates[ns-1] = rate_shadow[ns-1][cur-1];
                mism = rates[ns-1] != final_rate_r;
                rates[ns-2] = add_sat(rates[ns-2], bonus_r);
            end
            for (k = 0; k < nt; k++) begin
                res.stage = 4'(k);
                res.rate = rates[k];
                res.last = (k + 1 == nt);
                res.mismatch = mism;
                rate_expect_q.push_back(res);
            end
        end
    endtask

    // driver: holds each item until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) predict_stage_rates(cur_item);
            if (!i_valid || !o_stall) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur_item = pending_items.pop_front();
                    i_func <= cur_item.func;
                    i_row_index <= cur_item.row;
                    i_column_index <= cur_item.col;
                    i_data_value <= cur_item.data;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_go && hold_cnt == 0) hold_cnt <= HOLD_CYCLES;
        else if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    end

    // monitor: random stall and result checks
    always @(posedge i_clk) begin
        t_stage_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (rate_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result stage %0d", o_stage_index));
            end else begin
                exp_r = rate_expect_q.pop_front();
                if (o_stage_index !== exp_r.stage)
                    report_mismatch($sformatf("stage_index %0d, want %0d",
                                              o_stage_index, exp_r.stage));
                if (o_stage_rate !== exp_r.rate)
                    report_mismatch($sformatf("stage %0d rate %h, want %h",
                                              exp_r.stage, o_stage_rate, exp_r.rate));
                if (o_last !== exp_r.last)
                    report_mismatch($sformatf("stage %0d last %b, want %b",
                                              exp_r.stage, o_last, exp_r.last));
                if (o_rate_mismatch !== exp_r.mismatch)
                    report_mismatch($sformatf("stage %0d rate_mismatch %b, want %b",
                                              exp_r.stage, o_rate_mismatch, exp_r.mismatch));
            end
        end
        i_stall <= (hold_cnt != 0) || ($urandom_range(99) < stall_pct);
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_item(input logic [1:0] f, input int row, input int col,
                             input logic [31:0] d);
        t_item it;
        it.func = f;
        it.row = 4'(row);
        it.col = 4'(col);
        it.data = d;
        if (f == FUNC_WR_BP) bp_plan[row] = d[15:0];
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || i_valid) @(posedge i_clk);
        while (rate_expect_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_STAGE_COUNT:  stage_count_r = val[4:0];
            CFG_TOTAL_COUNT:  total_count_r = val[4:0];
            CFG_BP_COUNT:     bp_count_r = val[4:0];
            CFG_FINAL_RATE:   final_rate_r = val;
            CFG_PENULT_BONUS: bonus_r = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [4:0] sc, input logic [4:0] tc, input logic [4:0] bc,
                            input logic [31:0] fr, input logic [31:0] pb);
        write_cfg(CFG_STAGE_COUNT, {27'h0, sc});
        write_cfg(CFG_TOTAL_COUNT, {27'h0, tc});
        write_cfg(CFG_BP_COUNT, {27'h0, bc});
        write_cfg(CFG_FINAL_RATE, fr);
        write_cfg(CFG_PENULT_BONUS, pb);
    endtask

    // ascending breakpoints, or now and then an unordered set; only the
    // low entries are rewritten since breakpoint_count stays small
    task automatic load_breakpoints(input bit ordered);
        int k;
        logic [15:0] b;
        b = 16'($urandom_range(0, 300));
        for (k = 0; k < 8; k++) begin
            if (ordered) begin
                push_item(FUNC_WR_BP, k, 0, {$urandom_range(0, 65535) << 16 | 32'(b)});
                b = b + 16'($urandom_range(1, 4000));
            end else begin
                push_item(FUNC_WR_BP, k, 0, $urandom);
            end
        end
    endtask

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(3))
            0: return 32'($urandom_range(0, 255)) << 16;
            1: return $urandom;
            2: return 32'hFFFF_FFFF - 32'($urandom_range(0, 1000));
            default: return final_rate_r;
        endcase
    endfunction

    function automatic logic [31:0] pick_time();
        int k;
        k = $urandom_range(7);
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return {bp_plan[k], 16'h0};
            3: return {bp_plan[k], 16'h0} - 32'd1;
            4: return $urandom;
            default: return {bp_plan[k], 16'($urandom)};
        endcase
    endfunction

    // random part: mostly queries, some table rewrites and unused codes
    task automatic random_items(input int count);
        int n, p;
        for (n = 0; n < count; n++) begin
            p = $urandom_range(99);
            if (p < 60) push_item(FUNC_QUERY, $urandom_range(15), $urandom_range(15), pick_time());
            else if (p < 75) push_item(FUNC_WR_RATE, $urandom_range(15), $urandom_range(15),
                                       pick_rate());
            else if (p < 82) push_item(FUNC_WR_BP, $urandom_range(15), 0, $urandom);
            else if (p < 90) load_breakpoints($urandom_range(3) != 0);
            else push_item(FUNC_UNUSED, $urandom_range(15), $urandom_range(15), $urandom);
        end
    endtask

    initial begin
        int s, c;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // breakpoint_count stays at or below 5, so queries read rate columns 0 to 3
        set_regs(5'd5, 5'd5, 5'd5, 32'h0, 32'h0);

        // fill the breakpoint table and rate columns 0 to 3 so that no result uses an unwritten entry
        for (s = 0; s < 16; s++)
            for (c = 0; c < 4; c++)
                push_item(FUNC_WR_RATE, s, c, (s == 4 && c == 0) ? 32'h0 : pick_rate());
        for (s = 0; s < 16; s++) push_item(FUNC_WR_BP, s, 0, 32'(100 + s * 1000));

        // directed: below first breakpoint, on and between breakpoints, clamp, extremes
        push_item(FUNC_QUERY, 0, 0, 32'h0);
        push_item(FUNC_QUERY, 0, 0, {16'd100, 16'h0} - 32'd1);
        push_item(FUNC_QUERY, 0, 0, {16'd100, 16'h0});
        push_item(FUNC_QUERY, 0, 0, {16'd100, 16'h8000});
        push_item(FUNC_QUERY, 15, 15, {16'd3100, 16'h1234});
        push_item(FUNC_QUERY, 0, 0, {16'd15100, 16'h0});
        push_item(FUNC_QUERY, 0, 0, 32'hFFFF_FFFF);
        push_item(FUNC_WR_RATE, 0, 0, 32'hFFFF_FFFF);
        push_item(FUNC_WR_RATE, 0, 1, 32'hFFFF_FFFF);
        push_item(FUNC_QUERY, 0, 0, {16'd2100, 16'hFFFF});
        push_item(FUNC_UNUSED, 15, 15, 32'hFFFF_FFFF);
        push_item(FUNC_WR_BP, 4, 0, 32'hFFFF_FFFF);
        push_item(FUNC_QUERY, 0, 0, 32'hFFFF_0000);
        push_item(FUNC_QUERY, 0, 0, 32'hFFFE_FFFF);
        push_item(FUNC_WR_BP, 3, 0, 32'h0000_0000);
        push_item(FUNC_QUERY, 0, 0, {16'd2100, 16'h0001});
        push_item(FUNC_QUERY, 0, 0, {16'd6100, 16'h0});
        wait_idle();

        // phase: narrowest settings, sender gaps
        idle_pct = 56;
        stall_pct = 0;
        set_regs(5'd2, 5'd2, 5'd2, 32'h0, 32'h0);
        load_breakpoints(1);
        random_items(14);
        wait_idle();

        // phase: widest stage settings, receiver stalls, long hold-off
        idle_pct = 0;
        stall_pct = 56;
        set_regs(5'd16, 5'd16, 5'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(FUNC_WR_RATE, 15, 3, 32'hFFFF_FFFF);
        load_breakpoints(1);
        random_items(4);
        @(posedge i_clk);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        push_item(FUNC_QUERY, 0, 0, pick_time());
        random_items(10);
        wait_idle();

        // phase: out-of-range register values saturate
        idle_pct = 24;
        stall_pct = 24;
        set_regs(5'd31, 5'd0, 5'd0, $urandom, $urandom);
        load_breakpoints(1);
        random_items(12);
        wait_idle();

        // phase: mid settings, no idling
        idle_pct = 0;
        stall_pct = 0;
        set_regs(5'd3, 5'd9, 5'd5, 32'h0001_0000, 32'($urandom_range(0, 65535)));
        push_item(FUNC_WR_RATE, 2, 2, 32'h0001_0000);
        random_items(12);
        wait_idle();

        $display("run covered %0d queries, %0d table loads, %0d results checked",
                 n_queries, n_loads, n_results);
        $display("register sweeps: narrow, wide, saturated and mid; idle and stall mixes");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[stage_rate_time_interpolator.f]
rtl/core/srti_pkg.sv
rtl/core/srti_div.sv
rtl/core/stage_rate_time_interpolator.sv
rtl/core/srti_checker.sv
dv/tb.sv
